[hw/rtl/ihpq_pkg.sv]
// Package for the indexed heap priority queue.
// Holds command codes, beat structs and the controller command/status types.
// No dependencies.
`default_nettype none
package ihpq_pkg;
	localparam int unsigned MaxElemsDefault = 255;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_INVERT = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         elem_id;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]         count;
		logic [7:0]         top_id;
		logic               is_present;
		logic signed [31:0] elem_priority;
		logic               max_first;
	} out_beat_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_CLR_WR,
		OP_INV_START,
		OP_INS_START,
		OP_UP_RD,
		OP_UP_STEP,
		OP_DN_RD,
		OP_DN_STEP,
		OP_REM_RD,
		OP_REM_WR,
		OP_INV_NEXT,
		OP_INV_LOAD,
		OP_Q_RD2,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic       cmd_insert;
		logic       cmd_remove;
		logic       cmd_invert;
		logic       id_ok;
		logic       held;
		logic       full;
		logic       empty;
		logic       up_more;
		logic       dn_more;
		logic       inv_more;
	} dp_stat_t;
endpackage
`default_nettype wire

[hw/rtl/indexed_heap_priority_queue_unit.sv]
// Top level of the indexed heap priority queue.
// Depends on ihpq_pkg, ihpq_ctrl and ihpq_datapath.
//
// Usage: drive a command beat on in_beat and raise start; the beat is accepted at
// the rising edge where start is high and busy is low. Exactly one result beat
// appears on out_beat for one cycle with done high; the receiver cannot stall it.
// An insert walks the heap by sift-up and then sift-down, visiting at most nine
// levels in all; a remove walks it by sift-down only, visiting at most eight.
// Busy falls in the cycle after the result. Invert runs sift-down from each of
// count/2 internal slots in turn.
// One command is processed at a time; the sift walks set the rate.
// Reset clears the count, the order flag and the per-id valid bits of the
// position map at once; no clearing pass is needed.
`default_nettype none
module indexed_heap_priority_queue_unit import ihpq_pkg::*; #(
	parameter int unsigned MAX_ELEMS = MaxElemsDefault
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       start,
	output logic      busy,
	input  in_beat_t  in_beat,
	output logic      done,
	output out_beat_t out_beat
);
	dp_cmd_t  dcmd;
	dp_stat_t stat;

	ihpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.stat(stat), .dcmd(dcmd)
	);

	ihpq_datapath #(.MAX_ELEMS(MAX_ELEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_beat), .dcmd(dcmd),
		.stat(stat), .out_beat(out_beat)
	);
endmodule
`default_nettype wire

[hw/rtl/ihpq_datapath.sv]
// Datapath of the indexed heap priority queue: heap memories, map, sift unit.
// Depends on ihpq_pkg; driven by ihpq_ctrl through dp_cmd_t.
`default_nettype none
module ihpq_datapath import ihpq_pkg::*; #(
	parameter int unsigned MAX_ELEMS = MaxElemsDefault
) (
	input  wire       clk,
	input  wire       arst_n,
	input  in_beat_t  in_beat,
	input  dp_cmd_t   dcmd,
	output dp_stat_t  stat,
	output out_beat_t out_beat
);
	logic [7:0]         ids_mem [256];
	logic signed [31:0] pri_mem [256];
	logic [7:0]         map_mem [256];
	logic [255:0]       map_vld_q;

	logic [1:0]         cmd_q;
	logic [7:0]         id_q;
	logic signed [31:0] val_q;
	logic [7:0]         cnt_q;
	logic               ord_q;

	// Sift cursor and carried entry.
	logic [7:0]         pos_q;
	logic [7:0]         cid_q;
	logic signed [31:0] cpr_q;
	logic [7:0]         inv_q;
	logic [7:0]         mapv_q;

	// Registered read ports: parent/left, right, map.
	logic [7:0]         ra_id_q, rb_id_q;
	logic signed [31:0] ra_pr_q, rb_pr_q;

	logic [8:0] lpos, rpos;
	logic [7:0] par;
	logic       id_ok;

	function automatic logic goes_first(input logic o, input logic signed [31:0] a,
		input logic signed [31:0] b);
		goes_first = o ? (a > b) : (a < b);
	endfunction

	assign lpos  = {pos_q, 1'b0};
	assign rpos  = {pos_q, 1'b1};
	assign par   = {1'b0, pos_q[7:1]};
	assign id_ok = (id_q != 8'd0) && ({24'd0, id_q} <= MAX_ELEMS);

	logic       dn_has_r, dn_pick_r, dn_swap;
	logic [7:0] dn_pick;
	logic signed [31:0] dn_ppr;
	logic [7:0] dn_pid;
	assign dn_has_r  = rpos <= {1'b0, cnt_q};
	assign dn_pick_r = dn_has_r && goes_first(ord_q, rb_pr_q, ra_pr_q);
	assign dn_pick   = dn_pick_r ? rpos[7:0] : lpos[7:0];
	assign dn_ppr    = dn_pick_r ? rb_pr_q : ra_pr_q;
	assign dn_pid    = dn_pick_r ? rb_id_q : ra_id_q;
	assign dn_swap   = goes_first(ord_q, dn_ppr, cpr_q);

	logic up_swap;
	assign up_swap = (pos_q > 8'd1) && goes_first(ord_q, cpr_q, ra_pr_q);

	always_comb begin
		stat.cmd_insert = cmd_q == CMD_INSERT;
		stat.cmd_remove = cmd_q == CMD_REMOVE;
		stat.cmd_invert = cmd_q == CMD_INVERT;
		stat.id_ok      = id_ok;
		stat.held       = map_vld_q[id_q] && (mapv_q != 8'd0);
		stat.full       = cnt_q == 8'd255;
		stat.empty      = cnt_q == 8'd0;
		stat.up_more    = up_swap;
		stat.dn_more    = (lpos <= {1'b0, cnt_q}) && dn_swap;
		stat.inv_more   = inv_q > 8'd1;
	end

	always_ff @(posedge clk) begin
		unique case (dcmd.op)
			OP_UP_RD: begin
				ra_id_q <= ids_mem[par];
				ra_pr_q <= pri_mem[par];
			end
			OP_DN_RD: begin
				ra_id_q <= ids_mem[lpos[7:0]];
				ra_pr_q <= pri_mem[lpos[7:0]];
				rb_id_q <= ids_mem[rpos[7:0]];
				rb_pr_q <= pri_mem[rpos[7:0]];
			end
			OP_REM_RD: begin
				ra_id_q <= ids_mem[cnt_q];
				ra_pr_q <= pri_mem[cnt_q];
				rb_id_q <= ids_mem[8'd1];
			end
			OP_INV_NEXT: begin
				ra_id_q <= ids_mem[inv_q - 8'd1];
				ra_pr_q <= pri_mem[inv_q - 8'd1];
			end
			OP_Q_RD2: begin
				ra_pr_q <= pri_mem[mapv_q];
				ra_id_q <= ids_mem[8'd1];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mapv_q <= map_mem[id_q];
		unique case (dcmd.op)
			OP_INS_START: begin
				if (map_vld_q[id_q] && mapv_q != 8'd0) begin
					pos_q <= mapv_q;
				end else begin
					pos_q <= cnt_q + 8'd1;
				end
				cid_q <= id_q;
				cpr_q <= val_q;
			end
			OP_UP_STEP: begin
				if (up_swap) begin
					ids_mem[pos_q] <= ra_id_q;
					pri_mem[pos_q] <= ra_pr_q;
					map_mem[ra_id_q] <= pos_q;
					pos_q <= par;
				end else begin
					ids_mem[pos_q] <= cid_q;
					pri_mem[pos_q] <= cpr_q;
					map_mem[cid_q] <= pos_q;
				end
			end
			OP_DN_STEP: begin
				if ((lpos <= {1'b0, cnt_q}) && dn_swap) begin
					ids_mem[pos_q] <= dn_pid;
					pri_mem[pos_q] <= dn_ppr;
					map_mem[dn_pid] <= pos_q;
					ids_mem[dn_pick] <= cid_q;
					pri_mem[dn_pick] <= cpr_q;
					map_mem[cid_q] <= dn_pick;
					pos_q <= dn_pick;
				end
			end
			OP_REM_WR: begin
				map_mem[rb_id_q] <= 8'd0;
				ids_mem[8'd1] <= ra_id_q;
				pri_mem[8'd1] <= ra_pr_q;
				pos_q <= 8'd1;
				cid_q <= ra_id_q;
				cpr_q <= ra_pr_q;
			end
			OP_REM_RD: ;
			OP_INV_NEXT: pos_q <= inv_q - 8'd1;
			OP_CLR_WR: begin
				if (cnt_q != 8'd0) begin
					map_mem[ra_id_q] <= 8'd1;
				end
			end
			OP_INV_LOAD: begin
				cid_q <= ra_id_q;
				cpr_q <= ra_pr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q <= '0;
			cnt_q     <= '0;
			ord_q     <= 1'b0;
			inv_q     <= '0;
			cmd_q     <= CMD_QUERY;
			id_q      <= '0;
		end else begin
			unique case (dcmd.op)
				OP_LATCH: begin
					cmd_q <= in_beat.cmd;
					id_q  <= in_beat.elem_id;
				end
				OP_INS_START: begin
					map_vld_q[id_q] <= 1'b1;
					if (!(map_vld_q[id_q] && mapv_q != 8'd0)) begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				OP_UP_STEP: begin
					if (up_swap) begin
						map_vld_q[ra_id_q] <= 1'b1;
					end
				end
				OP_REM_WR: begin
					cnt_q <= cnt_q - 8'd1;
					if (cnt_q == 8'd1) begin
						map_vld_q[rb_id_q] <= 1'b0;
					end
				end
				OP_INV_START: begin
					ord_q <= ~ord_q;
					inv_q <= {1'b0, cnt_q[7:1]} + 8'd1;
				end
				OP_INV_NEXT: inv_q <= inv_q - 8'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == OP_LATCH) begin
			val_q <= in_beat.value;
		end
	end

	// Priority of the queried id, zero when it is absent.
	logic signed [31:0] q_pr;
	assign q_pr = (id_ok && map_vld_q[id_q] && mapv_q != 8'd0) ? ra_pr_q : 32'sd0;

	always_comb begin
		out_beat.count         = cnt_q;
		out_beat.top_id        = (cnt_q != 8'd0) ? ra_id_q : 8'd0;
		out_beat.is_present    = id_ok && map_vld_q[id_q] && mapv_q != 8'd0;
		out_beat.elem_priority = q_pr;
		out_beat.max_first     = ord_q;
	end
endmodule
`default_nettype wire

[hw/rtl/ihpq_ctrl.sv]
// Controller state machine of the indexed heap priority queue.
// Depends on ihpq_pkg; sequences ihpq_datapath through dp_cmd_t.
`default_nettype none
module ihpq_ctrl import ihpq_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  wire      start,
	output logic     busy,
	output logic     done,
	input  dp_stat_t stat,
	output dp_cmd_t  dcmd
);
	localparam logic [3:0] S_IDLE = 4'd0, S_MAP = 4'd1, S_DISP = 4'd2, S_UPR = 4'd3,
		S_UPS = 4'd4, S_DNR = 4'd5, S_DNS = 4'd6, S_REMR = 4'd7, S_REMW = 4'd8,
		S_INVR = 4'd9, S_INVL = 4'd10, S_QR = 4'd11, S_QR2 = 4'd12, S_OUT = 4'd13,
		S_LOAD = 4'd14;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		dcmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: if (start) begin
				dcmd.op = OP_LATCH;
				state_d = S_MAP;
			end
			S_MAP: state_d = S_DISP;
			S_DISP: begin
				priority if (stat.cmd_insert && stat.id_ok && (stat.held || !stat.full)) begin
					dcmd.op = OP_INS_START;
					state_d = S_UPR;
				end else if (stat.cmd_remove && !stat.empty) begin
					dcmd.op = OP_REM_RD;
					state_d = S_REMW;
				end else if (stat.cmd_invert) begin
					dcmd.op = OP_INV_START;
					state_d = S_INVL;
				end else begin
					state_d = S_QR;
				end
			end
			S_UPR: begin
				dcmd.op = OP_UP_RD;
				state_d = S_UPS;
			end
			S_UPS: begin
				dcmd.op = OP_UP_STEP;
				state_d = stat.up_more ? S_UPR : S_DNR;
			end
			S_DNR: begin
				dcmd.op = OP_DN_RD;
				state_d = S_DNS;
			end
			S_DNS: begin
				dcmd.op = OP_DN_STEP;
				priority if (stat.dn_more) state_d = S_DNR;
				else if (stat.cmd_invert) state_d = S_INVL;
				else state_d = S_QR;
			end
			S_REMW: begin
				dcmd.op = OP_REM_WR;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				dcmd.op = OP_CLR_WR;
				state_d = S_DNR;
			end
			S_INVL: begin
				if (stat.inv_more) begin
					dcmd.op = OP_INV_NEXT;
					state_d = S_INVR;
				end else begin
					state_d = S_QR;
				end
			end
			S_INVR: begin
				dcmd.op = OP_INV_LOAD;
				state_d = S_DNR;
			end
			S_QR: state_d = S_QR2;
			S_QR2: begin
				dcmd.op = OP_Q_RD2;
				state_d = S_OUT;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_done_after_q: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_QR2) else $error("done without read");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("no return to idle");
`endif
endmodule
`default_nettype wire

[test/tb_indexed_heap_priority_queue_unit.sv]
// Self-checking testbench for the indexed heap priority queue unit.
// A scoreboard class keeps its own heap and id map to predict every result beat.
// Depends on ihpq_pkg and indexed_heap_priority_queue_unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_indexed_heap_priority_queue_unit;
	import ihpq_pkg::*;

	class heap_scoreboard;
		logic [7:0]         ids [256];
		logic signed [31:0] prios [256];
		logic [7:0]         slot_of [256];
		int unsigned        n;
		bit                 max_first;
		out_beat_t          pending [$];
		int unsigned        errors;

		function new();
			foreach (slot_of[i]) slot_of[i] = '0;
			n = 0;
			max_first = 0;
			errors = 0;
		endfunction

		function bit ahead(logic signed [31:0] a, logic signed [31:0] b);
			return max_first ? (a > b) : (a < b);
		endfunction

		function void put(int unsigned p, logic [7:0] id, logic signed [31:0] v);
			ids[p] = id;
			prios[p] = v;
			slot_of[id] = p[7:0];
		endfunction

		function int unsigned rise(int unsigned p);
			logic [7:0]         id;
			logic signed [31:0] v;
			id = ids[p];
			v = prios[p];
			while (p > 1 && ahead(v, prios[p >> 1])) begin
				put(p, ids[p >> 1], prios[p >> 1]);
				p = p >> 1;
			end
			put(p, id, v);
			return p;
		endfunction

		function void sink(int unsigned p);
			int unsigned        c;
			logic [7:0]         id;
			logic signed [31:0] v;
			while (2 * p <= n) begin
				c = 2 * p;
				if (c + 1 <= n && ahead(prios[c + 1], prios[c])) c++;
				if (!ahead(prios[c], prios[p])) break;
				id = ids[p];
				v = prios[p];
				put(p, ids[c], prios[c]);
				put(c, id, v);
				p = c;
			end
		endfunction

		function void note_beat(in_beat_t b);
			out_beat_t   r;
			int unsigned p;
			bit          ok;
			ok = b.elem_id != 0;
			case (cmd_t'(b.cmd))
				CMD_INSERT: if (ok) begin
					p = {24'd0, slot_of[b.elem_id]};
					if (p != 0) begin
						prios[p] = b.value;
						p = rise(p);
						sink(p);
					end else if (n < 255) begin
						n++;
						put(n, b.elem_id, b.value);
						void'(rise(n));
					end
				end
				CMD_REMOVE: if (n != 0) begin
					slot_of[ids[1]] = 0;
					ids[1] = ids[n];
					prios[1] = prios[n];
					n--;
					if (n != 0) begin
						slot_of[ids[1]] = 1;
						sink(1);
					end
				end
				CMD_INVERT: begin
					max_first = !max_first;
					for (int i = n / 2; i >= 1; i--) sink(i);
				end
				default: ;
			endcase
			r.count = n[7:0];
			r.top_id = n != 0 ? ids[1] : 8'd0;
			r.is_present = ok && slot_of[b.elem_id] != 0;
			r.elem_priority = r.is_present ? prios[slot_of[b.elem_id]] : 32'sd0;
			r.max_first = max_first;
			pending.push_back(r);
		endfunction

		function void check_beat(out_beat_t a);
			out_beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.count !== e.count) begin
				$error("count: expected %0d, got %0d", e.count, a.count);
				errors++;
			end
			if (a.top_id !== e.top_id) begin
				$error("top_id: expected %0d, got %0d", e.top_id, a.top_id);
				errors++;
			end
			if (a.is_present !== e.is_present) begin
				$error("is_present: expected %0b, got %0b", e.is_present, a.is_present);
				errors++;
			end
			if (a.elem_priority !== e.elem_priority) begin
				$error("elem_priority: expected %0d, got %0d", e.elem_priority,
					a.elem_priority);
				errors++;
			end
			if (a.max_first !== e.max_first) begin
				$error("max_first: expected %0b, got %0b", e.max_first, a.max_first);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      start = 0;
	logic      busy;
	logic      done;
	in_beat_t  in_beat = '0;
	out_beat_t out_beat;
	int unsigned sender_idle = 0;
	heap_scoreboard heap_sb = new();

	indexed_heap_priority_queue_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_beat(in_beat), .done(done), .out_beat(out_beat)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (done) heap_sb.check_beat(out_beat);
	end

	task automatic send_cmd(cmd_t c, logic [7:0] id, logic signed [31:0] v);
		while ($urandom_range(99) < sender_idle) @(negedge clk);
		in_beat.cmd = c;
		in_beat.elem_id = id;
		in_beat.value = v;
		start = 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		heap_sb.note_beat(in_beat);
		@(negedge clk);
		start = 0;
	endtask

	task automatic drain();
		while (heap_sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_cmd(int unsigned span);
		int unsigned k;
		logic signed [31:0] v;
		k = $urandom_range(99);
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $signed($urandom_range(8)) - 4;
			2: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: v = $signed($urandom_range(200000)) - 100000;
		endcase
		if (k < 50)
			send_cmd(CMD_INSERT, 8'($urandom_range(span)), v);
		else if (k < 75)
			send_cmd(CMD_REMOVE, 8'($urandom_range(255)), v);
		else if (k < 80)
			send_cmd(CMD_INVERT, 8'($urandom_range(255)), v);
		else
			send_cmd(CMD_QUERY, 8'($urandom_range(k < 85 ? 255 : span)), v);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_cmd(CMD_QUERY, 8'd0, 32'sd0);
		send_cmd(CMD_REMOVE, 8'd5, 32'sd0);
		send_cmd(CMD_INSERT, 8'd0, 32'sd9);
		send_cmd(CMD_INSERT, 8'd255, 32'sh7fffffff);
		send_cmd(CMD_INSERT, 8'd1, 32'sh80000000);
		send_cmd(CMD_INSERT, 8'd7, 32'sd0);
		send_cmd(CMD_INSERT, 8'd9, 32'sd0);
		send_cmd(CMD_INSERT, 8'd170, 32'sh55555555);
		send_cmd(CMD_INSERT, 8'd85, -32'sh55555556);
		send_cmd(CMD_QUERY, 8'd255, 32'sd0);
		send_cmd(CMD_INSERT, 8'd255, -32'sd1);
		send_cmd(CMD_INVERT, 8'd1, 32'sd0);
		send_cmd(CMD_QUERY, 8'd9, 32'sd0);
		send_cmd(CMD_REMOVE, 8'd7, 32'sd0);
		send_cmd(CMD_INVERT, 8'd0, 32'sd0);
		for (int i = 0; i < 7; i++) send_cmd(CMD_REMOVE, 8'd255, 32'sd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle = ph == 0 ? 0 : ph == 1 ? 75 : ph == 2 ? 32 : 0;
			for (int i = 0; i < 300; i++) random_cmd(ph == 3 ? 12 : 40);
			drain();
		end
		sender_idle = 0;
		for (int i = 0; i < 260; i++) send_cmd(CMD_INSERT, 8'($urandom_range(255)), $urandom);
		for (int i = 0; i < 520; i++) random_cmd(255);
		drain();

		if (heap_sb.errors == 0 && heap_sb.pending.size() == 0)
			$display("tb_indexed_heap_priority_queue_unit: done, clean");
		else
			$display("tb_indexed_heap_priority_queue_unit: done, errors");
		$finish;
	end

	initial begin
		#40ms;
		$display("tb_indexed_heap_priority_queue_unit: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
